// File: src/vtpd_pkg.sv
// Package with types and constants shared by the vertex transform block.
`default_nettype none
package vtpd_pkg;
  localparam int unsigned FracBitsDefault = 16;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned RegW = 64;
  localparam int unsigned CfgIdxW = 3;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] x_in;
    logic signed [31:0] y_in;
    logic signed [31:0] z_in;
    logic signed [31:0] w_in;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
    logic signed [31:0] w_out;
    logic               divided;
    logic               saturated;
  } out_item_t;

  // Transformed vertex travelling from the matrix stages to the divider.
  typedef struct packed {
    logic               kind;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] w;
    logic               sat;
  } xf_item_t;

  localparam logic [RegW-1:0] RegReset [NumRegs] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };
endpackage
`default_nettype wire

// File: src/vtpd_matrix.sv
// Matrix-vector multiply: products, row sums, then shift and clamp, one stage each.
`default_nettype none
module vtpd_matrix import vtpd_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [RegW-1:0]     regs_i [NumRegs],
  input  wire logic                valid_i,
  input  wire in_item_t            item_i,
  output logic                     valid_o,
  output xf_item_t                 item_o
);
  logic signed [63:0] prod_q [16];
  logic               kind1_q, kind2_q;
  logic [2:0]         vld_q;
  logic signed [65:0] sum_q [4];

  logic signed [31:0] vec [4];
  assign vec[0] = item_i.x_in;
  assign vec[1] = item_i.y_in;
  assign vec[2] = item_i.z_in;
  assign vec[3] = item_i.w_in;

  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[r*4+c] <= $signed(regs_i[r*2 + c/2][(c%2)*32 +: 32]) * vec[c];
      end
    end
    kind1_q <= item_i.kind;
    for (int r = 0; r < 4; r++) begin
      sum_q[r] <= 66'(prod_q[r*4]) + 66'(prod_q[r*4+1])
                + 66'(prod_q[r*4+2]) + 66'(prod_q[r*4+3]);
    end
    kind2_q <= kind1_q;
  end

  // Arithmetic shift floors; then clamp to 32 bits.
  logic signed [65:0] shf [4];
  logic signed [31:0] res [4];
  logic               sat_d;
  always_comb begin
    sat_d = 1'b0;
    for (int r = 0; r < 4; r++) begin
      shf[r] = sum_q[r] >>> FracBits;
      if (shf[r] > 66'sd2147483647) begin
        res[r] = 32'h7fffffff; sat_d = 1'b1;
      end else if (shf[r] < -66'sd2147483648) begin
        res[r] = 32'h80000000; sat_d = 1'b1;
      end else begin
        res[r] = shf[r][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_o <= '{kind: kind2_q, x: res[0], y: res[1], z: res[2], w: res[3], sat: sat_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end
  assign valid_o = vld_q[2];
endmodule
`default_nettype wire

// File: src/vtpd_divider.sv
// Pipelined restoring divider for the three components, one quotient bit a stage.
`default_nettype none
module vtpd_divider import vtpd_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  input  wire xf_item_t  item_i,
  output logic           valid_o,
  output out_item_t      item_o
);
  localparam int unsigned NW = 32 + FracBits;  // numerator magnitude width
  localparam int unsigned NS = NW + 1;         // stages: entry plus one per bit

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [NW-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic [31:0] dmag;
    logic        qneg0, qneg1, qneg2;
    logic        divide;
    xf_item_t    xf;
  } ctl_t;

  lane_t       lane_q [NS][3];
  ctl_t        ctl_q  [NS];
  logic [NS-1:0] vld_q;

  // Stage 0 forms magnitudes; later stages retire one bit each.
  logic signed [31:0] comp [3];
  assign comp[0] = item_i.x;
  assign comp[1] = item_i.y;
  assign comp[2] = item_i.z;
  logic [31:0] wmag;
  assign wmag = item_i.w[31] ? 32'(-item_i.w) : item_i.w;

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < 3; l++) begin
      lane_q[0][l].rem <= '0;
      lane_q[0][l].quo <= {(comp[l][31] ? 32'(-comp[l]) : comp[l]), {FracBits{1'b0}}};
    end
    ctl_q[0].dmag   <= wmag;
    ctl_q[0].qneg0  <= comp[0][31] ^ item_i.w[31];
    ctl_q[0].qneg1  <= comp[1][31] ^ item_i.w[31];
    ctl_q[0].qneg2  <= comp[2][31] ^ item_i.w[31];
    ctl_q[0].divide <= item_i.kind && (item_i.w != 32'sd0);
    ctl_q[0].xf     <= item_i;
    for (int s = 1; s < NS; s++) begin
      ctl_q[s] <= ctl_q[s-1];
      for (int l = 0; l < 3; l++) begin
        logic [NW:0] trial;
        trial = {lane_q[s-1][l].rem, lane_q[s-1][l].quo[NW-1]};
        if (trial >= {{(NW-31){1'b0}}, ctl_q[s-1].dmag}) begin
          lane_q[s][l].rem <= NW'(trial - {{(NW-31){1'b0}}, ctl_q[s-1].dmag});
          lane_q[s][l].quo <= {lane_q[s-1][l].quo[NW-2:0], 1'b1};
        end else begin
          lane_q[s][l].rem <= trial[NW-1:0];
          lane_q[s][l].quo <= {lane_q[s-1][l].quo[NW-2:0], 1'b0};
        end
      end
    end
  end

  // Sign and clamp of the quotients.
  logic [2:0]         qn;
  logic signed [31:0] qv [3];
  logic               dsat;
  always_comb begin
    qn = {ctl_q[NS-1].qneg2, ctl_q[NS-1].qneg1, ctl_q[NS-1].qneg0};
    dsat = 1'b0;
    for (int l = 0; l < 3; l++) begin
      logic [NW-1:0] m;
      m = lane_q[NS-1][l].quo;
      if (qn[l]) begin
        if (m > NW'(33'h80000000)) begin
          qv[l] = 32'h80000000; dsat = 1'b1;
        end else begin
          qv[l] = 32'(-m);
        end
      end else if (m > NW'(32'h7fffffff)) begin
        qv[l] = 32'h7fffffff; dsat = 1'b1;
      end else begin
        qv[l] = m[31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_q[NS-1].divide) begin
      item_o <= '{x_out: qv[0], y_out: qv[1], z_out: qv[2], w_out: ctl_q[NS-1].xf.w,
                  divided: 1'b1, saturated: ctl_q[NS-1].xf.sat | dsat};
    end else begin
      item_o <= '{x_out: ctl_q[NS-1].xf.x, y_out: ctl_q[NS-1].xf.y,
                  z_out: ctl_q[NS-1].xf.z, w_out: ctl_q[NS-1].xf.w,
                  divided: 1'b0, saturated: ctl_q[NS-1].xf.sat};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      valid_o <= 1'b0;
    end else begin
      vld_q   <= {vld_q[NS-2:0], valid_i};
      valid_o <= vld_q[NS-1];
    end
  end
endmodule
`default_nettype wire

// File: src/vertex_transform_perspective_divide.sv
// Top level of the vertex transform with perspective divide.
// A new item is taken every cycle (busy is always low). Its result appears on result_o
// with done_o high for one cycle. The path is three register stages of matrix
// multiply, sum and clamp, then a divider
// pipeline of one quotient bit per stage over 32+FracBits bits, plus entry and output
// registers. The receiver cannot stall the stream. Matrix writes through cfg_we_i take
// effect on the next edge.
`default_nettype none
module vertex_transform_perspective_divide import vtpd_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire in_item_t           item_i,
  output logic                    done_o,
  output out_item_t               result_o,
  input  wire logic               cfg_we_i,
  input  wire logic [CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [RegW-1:0]    cfg_data_i
);
  logic [RegW-1:0] regs_q [NumRegs];
  logic            xf_vld;
  xf_item_t        xf_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumRegs; i++) regs_q[i] <= RegReset[i];
    end else if (cfg_we_i) begin
      regs_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  assign busy = 1'b0;

  vtpd_matrix #(.FracBits(FracBits)) u_matrix (
    .clk_i, .rst_ni, .regs_i(regs_q), .valid_i(start && !busy), .item_i,
    .valid_o(xf_vld), .item_o(xf_item)
  );

  vtpd_divider #(.FracBits(FracBits)) u_divider (
    .clk_i, .rst_ni, .valid_i(xf_vld), .item_i(xf_item),
    .valid_o(done_o), .item_o(result_o)
  );
endmodule
`default_nettype wire

// File: tb/sv/vertex_transform_perspective_divide_test.sv
// Testbench for the vertex transform with perspective divide.
`default_nettype none
module vertex_transform_perspective_divide_test;
  import vtpd_pkg::*;

  localparam int unsigned Frac = FracBitsDefault;
  localparam int unsigned Latency = Frac + 41;
  localparam longint MaxI32 = 64'sd2147483647;
  localparam longint MinI32 = -64'sd2147483648;
  localparam int unsigned CycleLimit = 400000;

  // Expected vertices in arrival order, computed from a private copy of the matrix.
  class vertex_scoreboard;
    logic [RegW-1:0] matrix_regs [NumRegs];
    out_item_t pending_q [$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < NumRegs; i++) matrix_regs[i] = RegReset[i];
      mismatches = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [RegW-1:0] data);
      if (idx < NumRegs) matrix_regs[idx] = data;
    endfunction

    function longint elem(int unsigned r, int unsigned c);
      logic [RegW-1:0] reg_val;
      logic signed [31:0] half;
      reg_val = matrix_regs[r * 2 + c / 2];
      half = (c % 2) ? reg_val[63:32] : reg_val[31:0];
      return longint'(half);
    endfunction

    // Exact row sum in 128 bits, floor shift, then clamp.
    function longint row_sum(int unsigned r, longint vec [4], ref bit sat);
      logic signed [127:0] acc;
      logic signed [127:0] shifted;
      acc = '0;
      for (int c = 0; c < 4; c++) acc += 128'(elem(r, c)) * 128'(vec[c]);
      shifted = acc >>> Frac;
      if (shifted > MaxI32) begin
        sat = 1;
        return MaxI32;
      end
      if (shifted < MinI32) begin
        sat = 1;
        return MinI32;
      end
      return longint'(shifted);
    endfunction

    function void note_vertex(in_item_t it);
      longint vec [4];
      longint res [4];
      longint quo;
      bit sat;
      bit div;
      out_item_t exp_item;
      sat = 0;
      div = 0;
      vec[0] = it.x_in;
      vec[1] = it.y_in;
      vec[2] = it.z_in;
      vec[3] = it.w_in;
      for (int r = 0; r < 4; r++) res[r] = row_sum(r, vec, sat);
      if (it.kind && res[3] != 0) begin
        div = 1;
        for (int r = 0; r < 3; r++) begin
          quo = (res[r] * (64'sd1 <<< Frac)) / res[3];
          if (quo > MaxI32) begin
            quo = MaxI32;
            sat = 1;
          end else if (quo < MinI32) begin
            quo = MinI32;
            sat = 1;
          end
          res[r] = quo;
        end
      end
      exp_item.x_out = res[0][31:0];
      exp_item.y_out = res[1][31:0];
      exp_item.z_out = res[2][31:0];
      exp_item.w_out = res[3][31:0];
      exp_item.divided = div;
      exp_item.saturated = sat;
      pending_q.push_back(exp_item);
    endfunction

    function void check_vertex(out_item_t got);
      out_item_t want;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_q.pop_front();
      if (got.x_out !== want.x_out || got.y_out !== want.y_out ||
          got.z_out !== want.z_out || got.w_out !== want.w_out ||
          got.divided !== want.divided || got.saturated !== want.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected x %h y %h z %h w %h div %b sat %b, ",
                    "got x %h y %h z %h w %h div %b sat %b"},
                   want.x_out, want.y_out, want.z_out, want.w_out, want.divided,
                   want.saturated, got.x_out, got.y_out, got.z_out, got.w_out,
                   got.divided, got.saturated);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic start = 0;
  logic busy;
  in_item_t item_i = '0;
  logic done_o;
  out_item_t result_o;
  logic cfg_we_i = 0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [RegW-1:0] cfg_data_i = '0;

  vertex_transform_perspective_divide uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .item_i(item_i),
    .done_o(done_o), .result_o(result_o), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  vertex_scoreboard board = new();
  int unsigned idle_pct = 0;
  longint unsigned cycles = 0;

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (rst_ni && done_o) board.check_vertex(result_o);
    if (cycles > CycleLimit) begin
      $display("vertex_transform_perspective_divide_test NOT OK");
      $finish;
    end
  end

  // The write enable stays high so that writes can follow back to back; the caller
  // lowers it after the last one.
  task automatic write_reg(int unsigned idx, logic [RegW-1:0] data);
    cfg_we_i <= 1;
    cfg_idx_i <= idx[CfgIdxW-1:0];
    cfg_data_i <= data;
    @(posedge clk_i);
    board.write_reg(idx, data);
  endtask

  // Hands one vertex over; start stays high when the next one follows at once.
  task automatic send_vertex(in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk_i);
    end
    start <= 1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    board.note_vertex(it);
  endtask

  task automatic drain();
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_comp();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return $urandom_range(65536 * 8) - 65536 * 4;
      3: return 32'($urandom_range(16) - 8) << 16;
      default: return $urandom;
    endcase
  endfunction

  function automatic in_item_t rand_vertex();
    in_item_t it;
    it.kind = $urandom_range(1);
    it.x_in = pick_comp();
    it.y_in = pick_comp();
    it.z_in = pick_comp();
    it.w_in = ($urandom_range(7) == 0) ? 32'd0 : pick_comp();
    return it;
  endfunction

  function automatic logic [RegW-1:0] rand_row(int mode);
    logic [31:0] a;
    logic [31:0] b;
    case (mode)
      0: begin
        a = $urandom_range(65536 * 4) - 65536 * 2;
        b = $urandom_range(65536 * 4) - 65536 * 2;
      end
      1: begin
        a = 32'h8000_0000;
        b = 32'h7fff_ffff;
      end
      default: begin
        a = $urandom;
        b = $urandom;
      end
    endcase
    return {b, a};
  endfunction

  task automatic load_matrix(int mode);
    for (int i = 0; i < NumRegs; i++) write_reg(i, rand_row(mode));
    cfg_we_i <= 0;
  endtask

  task automatic directed();
    in_item_t it;
    logic [31:0] ext [4] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff};
    for (int k = 0; k < 4; k++) begin
      it.kind = k[0];
      it.x_in = ext[k];
      it.y_in = ext[(k + 1) % 4];
      it.z_in = ext[(k + 2) % 4];
      it.w_in = ext[(k + 3) % 4];
      send_vertex(it);
    end
    // Projection with an input w of zero passes undivided under the reset matrix.
    it = '{kind: 1, x_in: 32'h0002_0000, y_in: 32'h0001_0000, z_in: 32'h0003_0000,
           w_in: 32'h0};
    send_vertex(it);
    it.w_in = 32'h0002_0000;
    send_vertex(it);
    it.w_in = 32'hfffe_0000;
    send_vertex(it);
    // Under the reset matrix, tiny w forces the quotients into saturation.
    it = '{kind: 1, x_in: 32'h7fff_0000, y_in: 32'h8000_0000, z_in: 32'h1, w_in: 32'h1};
    send_vertex(it);
    it.kind = 0;
    send_vertex(it);
    start <= 0;
  endtask

  task automatic random_phase(int unsigned count, int unsigned pct);
    idle_pct = pct;
    for (int unsigned n = 0; n < count; n++) send_vertex(rand_vertex());
    start <= 0;
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    directed();
    drain();
    // Extreme matrix elements drive the row sums into clamping.
    load_matrix(1);
    directed();
    drain();
    load_matrix(0);
    random_phase(400, 0);
    load_matrix(2);
    random_phase(350, 79);
    load_matrix(0);
    random_phase(400, 18);
    write_reg(0, 64'h0);
    for (int i = 1; i < NumRegs; i++) write_reg(i, {64{1'b1}});
    cfg_we_i <= 0;
    random_phase(100, 0);
    load_matrix(0);
    random_phase(250, 0);
    if (board.mismatches == 0 && board.pending_q.size() == 0) begin
      $display("vertex_transform_perspective_divide_test OK");
    end else begin
      $display("vertex_transform_perspective_divide_test NOT OK");
    end
    $finish;
  end
endmodule
`default_nettype wire
